// ----- hdl/i128alu_pkg.sv -----
// shared types and opcode constants for the 128-bit wrapping alu
// no dependencies
package i128alu_pkg;

    typedef enum logic [3:0] {
        OP_ADD    = 4'd0,
        OP_SUB    = 4'd1,
        OP_MUL    = 4'd2,
        OP_NEG    = 4'd3,
        OP_AND    = 4'd4,
        OP_OR     = 4'd5,
        OP_XOR    = 4'd6,
        OP_NOT    = 4'd7,
        OP_SHL    = 4'd8,
        OP_SHR    = 4'd9,
        OP_DIV    = 4'd10,
        OP_REM    = 4'd11,
        OP_POW    = 4'd12,
        OP_ASUINT = 4'd13,
        OP_ASINT  = 4'd14,
        OP_RSVD   = 4'd15
    } op_t;

    localparam int W = 128;

    // one multiply request to the shared 128x128 wrapping multiplier
    typedef struct packed {
        logic         start;
        logic [W-1:0] x;
        logic [W-1:0] y;
    } mul_req_t;

    typedef struct packed {
        logic         done;
        logic [W-1:0] p;
    } mul_rsp_t;

endpackage

// ----- hdl/i128alu_mul.sv -----
// wrapping 128x128 multiplier built from one shared 32x32 multiplier
// iterates over the ten partial products that land below bit 128; uses i128alu_pkg
module i128alu_mul (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  i128alu_pkg::mul_req_t req,
    output i128alu_pkg::mul_rsp_t rsp
);
    import i128alu_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_MUL, S_ACC, S_DONE} state_t;

    state_t        state_reg;
    logic [W-1:0]  x_reg, y_reg, acc_reg;
    logic [1:0]    i_reg, j_reg;
    logic [63:0]   prod_reg;
    logic [1:0]    pi_reg, pj_reg;
    logic [31:0]   xs, ys;
    logic [2:0]    pos;
    logic [W-1:0]  term;

    always_comb begin
        xs   = x_reg[32*i_reg +: 32];
        ys   = y_reg[32*j_reg +: 32];
        pos  = {1'b0, pi_reg} + {1'b0, pj_reg};
        term = {64'd0, prod_reg} << (32 * pos);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    if (req.start) begin
                        x_reg     <= req.x;
                        y_reg     <= req.y;
                        acc_reg   <= '0;
                        i_reg     <= 2'd0;
                        j_reg     <= 2'd0;
                        state_reg <= S_MUL;
                    end
                end
                S_MUL: begin
                    prod_reg  <= 64'(xs) * 64'(ys);
                    pi_reg    <= i_reg;
                    pj_reg    <= j_reg;
                    state_reg <= S_ACC;
                end
                S_ACC: begin
                    acc_reg <= acc_reg + term;
                    // walk pairs with i + j <= 3
                    if ({1'b0, i_reg} + {1'b0, j_reg} >= 3'd3) begin
                        if (i_reg == 2'd3) begin
                            state_reg <= S_DONE;
                        end else begin
                            i_reg     <= i_reg + 2'd1;
                            j_reg     <= 2'd0;
                            state_reg <= S_MUL;
                        end
                    end else begin
                        j_reg     <= j_reg + 2'd1;
                        state_reg <= S_MUL;
                    end
                end
                S_DONE: begin
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign rsp.done = (state_reg == S_DONE);
    assign rsp.p    = acc_reg;

endmodule

// ----- hdl/int128_wrapping_alu.sv -----
// top level of the 128-bit wrapping alu: stream ports, sequencer, divider and
// power loops; uses i128alu_pkg and i128alu_mul
//
//  channel | direction | tdata fields (low bit up)                  | tuser
//  s_      | in        | a_hi, a_lo, b_hi, b_lo (256 bits)          | action
//  m_      | out       | res_hi, res_lo (128 bits)                  | ok
//
// simple ops are computed in the exec state and registered; mul makes ten passes
// of the 32x32 multiplier; div and rem run one restoring step a cycle; pow does
// up to 128 squarings plus multiplies on the same multiplier.
// the block takes one item at a time; s_tready is low until the result is taken.
// reset is synchronous, active low, and clears the sequencer and valid flags.
module int128_wrapping_alu (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [255:0] s_tdata,   // a_hi, a_lo, b_hi, b_lo
    input  logic [3:0]   s_tuser,   // action
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,   // res_hi, res_lo
    output logic         m_tuser    // ok
);
    import i128alu_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_EXEC, S_DIV, S_DFIX, S_PSTEP, S_PWAIT, S_MWAIT, S_OUT
    } state_t;

    state_t        state_reg;
    op_t           op_reg;
    logic [W-1:0]  a_reg, b_reg, r_reg, q_reg, rm_reg, bm_reg;
    logic [W-1:0]  base_reg, e_reg;
    logic          ok_reg, pmul_sq_reg, started_reg;
    logic [6:0]    cnt_reg;
    mul_req_t      mreq;
    mul_rsp_t      mrsp;

    logic [W-1:0]  a_in, b_in, am, bm, shl_r, shr_r, tr_r, mask, simple_r;
    logic [W-1:0]  rr_sh, rr_diff;
    logic [W:0]    rr_sub;
    logic          b_neg, a_neg, big;
    logic [6:0]    sh;
    logic [6:0]    nb;

    assign a_in = {s_tdata[63:0], s_tdata[127:64]};
    assign b_in = {s_tdata[191:128], s_tdata[255:192]};

    always_comb begin
        a_neg = a_reg[W-1];
        b_neg = b_reg[W-1];
        am    = a_neg ? -a_reg : a_reg;
        bm    = b_neg ? -b_reg : b_reg;
        big   = (bm[W-1:7] != '0);
        sh    = bm[6:0];
        shl_r = big ? '0 : (a_reg << sh);
        shr_r = big ? {W{a_neg}} : W'($signed(a_reg) >>> sh);
        nb    = b_reg[6:0];
        mask  = ({{(W-1){1'b0}}, 1'b1} << nb) - W'(1);
        if (b_reg[63:0] == 64'd0) begin
            tr_r = '0;
        end else if (b_reg[63:7] != '0) begin
            tr_r = a_reg;
        end else if (op_reg == OP_ASINT && a_reg[nb - 7'd1]) begin
            tr_r = a_reg | ~mask;
        end else begin
            tr_r = a_reg & mask;
        end
        case (op_reg) inside
            OP_ADD:    simple_r = a_reg + b_reg;
            OP_SUB:    simple_r = a_reg - b_reg;
            OP_NEG:    simple_r = -a_reg;
            OP_AND:    simple_r = a_reg & b_reg;
            OP_OR:     simple_r = a_reg | b_reg;
            OP_XOR:    simple_r = a_reg ^ b_reg;
            OP_NOT:    simple_r = ~a_reg;
            OP_SHL:    simple_r = b_neg ? shr_r : shl_r;
            OP_SHR:    simple_r = b_neg ? shl_r : shr_r;
            OP_ASUINT, OP_ASINT: simple_r = tr_r;
            default:   simple_r = '0;
        endcase
        // one restoring division step: shift in next dividend bit
        rr_sh   = {rm_reg[W-2:0], q_reg[W-1]};
        rr_sub  = {1'b0, rr_sh} - {1'b0, bm_reg};
        rr_diff = rr_sub[W-1:0];
    end

    i128alu_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mreq),
        .rsp     (mrsp)
    );

    always_comb begin
        mreq.start = 1'b0;
        mreq.x     = r_reg;
        mreq.y     = base_reg;
        if (state_reg == S_EXEC && op_reg == OP_MUL) begin
            mreq.start = 1'b1;
            mreq.x     = a_reg;
            mreq.y     = b_reg;
        end else if (state_reg == S_PSTEP) begin
            mreq.start = 1'b1;
            if (pmul_sq_reg) begin
                mreq.x = base_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        op_reg    <= op_t'(s_tuser);
                        a_reg     <= a_in;
                        b_reg     <= b_in;
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    ok_reg <= 1'b1;
                    unique case (op_reg) inside
                        OP_MUL: state_reg <= S_MWAIT;
                        OP_DIV, OP_REM: begin
                            if (b_reg == '0) begin
                                ok_reg    <= 1'b0;
                                r_reg     <= '0;
                                state_reg <= S_OUT;
                            end else begin
                                q_reg     <= am;
                                rm_reg    <= '0;
                                bm_reg    <= bm;
                                cnt_reg   <= '0;
                                state_reg <= S_DIV;
                            end
                        end
                        OP_POW: begin
                            r_reg       <= W'(1);
                            base_reg    <= a_reg;
                            e_reg       <= b_reg;
                            started_reg <= 1'b0;
                            state_reg   <= S_PWAIT;
                        end
                        default: begin
                            r_reg     <= simple_r;
                            state_reg <= S_OUT;
                        end
                    endcase
                end
                S_DIV: begin
                    if (!rr_sub[W]) begin
                        rm_reg <= rr_diff;
                        q_reg  <= {q_reg[W-2:0], 1'b1};
                    end else begin
                        rm_reg <= rr_sh;
                        q_reg  <= {q_reg[W-2:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg + 7'd1;
                    if (cnt_reg == 7'd127) begin
                        state_reg <= S_DFIX;
                    end
                end
                S_DFIX: begin
                    if (op_reg == OP_DIV) begin
                        r_reg <= (a_neg != b_neg) ? -q_reg : q_reg;
                    end else begin
                        r_reg <= a_neg ? -rm_reg : rm_reg;
                    end
                    state_reg <= S_OUT;
                end
                S_PSTEP: begin
                    state_reg <= S_PWAIT;
                end
                S_PWAIT: begin
                    // decide next pow action when multiplier is free
                    if (started_reg && !mrsp.done) begin
                        state_reg <= S_PWAIT;
                    end else begin
                        if (started_reg) begin
                            if (pmul_sq_reg) begin
                                base_reg <= mrsp.p;
                                e_reg    <= e_reg >> 1;
                            end else begin
                                r_reg <= mrsp.p;
                            end
                        end
                        started_reg <= 1'b1;
                        if (started_reg && !pmul_sq_reg) begin
                            pmul_sq_reg <= 1'b1;
                            state_reg   <= S_PSTEP;
                        end else if ((started_reg && pmul_sq_reg ? (e_reg >> 1)
                                                                 : e_reg) == '0) begin
                            state_reg <= S_OUT;
                        end else begin
                            pmul_sq_reg <= !(started_reg && pmul_sq_reg ? e_reg[1]
                                                                        : e_reg[0]);
                            state_reg   <= S_PSTEP;
                        end
                    end
                end
                S_MWAIT: begin
                    if (mrsp.done) begin
                        r_reg     <= mrsp.p;
                        ok_reg    <= 1'b1;
                        state_reg <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (m_tready) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_OUT);
    assign m_tdata  = {r_reg[63:0], r_reg[127:64]};
    assign m_tuser  = ok_reg;

endmodule

// ----- bench/int128_wrapping_alu_tb.sv -----
// self-checking bench for int128_wrapping_alu: directed corner items, then random
// items under three idling phases, each result checked against an in-bench predictor
// depends on i128alu_pkg and the int128_wrapping_alu rtl
module int128_wrapping_alu_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import i128alu_pkg::*;

    typedef struct packed {
        op_t          op;
        logic [127:0] a;
        logic [127:0] b;
    } alu_item_t;

    typedef struct packed {
        logic         ok;
        logic [127:0] res;
    } alu_result_t;

    localparam logic [127:0] MIN128  = 128'd1 << 127;
    localparam logic [127:0] ONES128 = ~128'd0;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [255:0] s_tdata = '0;
    logic [3:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [127:0] m_tdata;
    logic         m_tuser;

    alu_item_t   pending_items[$];
    alu_result_t expected_results[$];
    int          items_sent = 0;
    int          results_seen = 0;
    int          mismatches = 0;
    int          idle_phase = 0;   // 0: sender 27/receiver 59, 1: swapped, 2: none

    int128_wrapping_alu dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic logic [127:0] shift_left_mag(logic [127:0] a, logic [127:0] m);
        if (m >= 128) return '0;
        return a << m[6:0];
    endfunction

    function automatic logic [127:0] shift_right_mag(logic [127:0] a, logic [127:0] m);
        if (m >= 128) return a[127] ? ONES128 : '0;
        return $unsigned($signed(a) >>> m[6:0]);
    endfunction

    function automatic logic [127:0] truncate_to(logic [127:0] a, logic [63:0] bits,
                                                 bit sign_extend);
        logic [127:0] mask;
        logic [127:0] r;
        if (bits == 0) return '0;
        if (bits >= 128) return a;
        mask = (128'd1 << bits[6:0]) - 128'd1;
        r = a & mask;
        if (sign_extend && r[bits[6:0] - 7'd1]) r = r | ~mask;
        return r;
    endfunction

    function automatic alu_result_t alu_expect(alu_item_t it);
        alu_result_t  e;
        logic [127:0] a, b, am, bm, q, rm, base, ex;
        a = it.a;
        b = it.b;
        e.ok = 1'b1;
        e.res = '0;
        am = a[127] ? -a : a;
        bm = b[127] ? -b : b;
        case (it.op) inside
            OP_ADD: e.res = a + b;
            OP_SUB: e.res = a - b;
            OP_MUL: e.res = a * b;
            OP_NEG: e.res = -a;
            OP_AND: e.res = a & b;
            OP_OR:  e.res = a | b;
            OP_XOR: e.res = a ^ b;
            OP_NOT: e.res = ~a;
            OP_SHL: e.res = b[127] ? shift_right_mag(a, bm) : shift_left_mag(a, bm);
            OP_SHR: e.res = b[127] ? shift_left_mag(a, bm) : shift_right_mag(a, bm);
            OP_DIV, OP_REM: begin
                if (b == 0) begin
                    e.ok = 1'b0;
                end else begin
                    q = am / bm;
                    rm = am % bm;
                    if (it.op == OP_DIV) e.res = (a[127] != b[127]) ? -q : q;
                    else e.res = a[127] ? -rm : rm;
                end
            end
            OP_POW: begin
                e.res = 128'd1;
                base = a;
                ex = b;
                while (ex != 0) begin
                    if (ex[0]) e.res = e.res * base;
                    base = base * base;
                    ex = ex >> 1;
                end
            end
            OP_ASUINT: e.res = truncate_to(a, b[63:0], 1'b0);
            OP_ASINT:  e.res = truncate_to(a, b[63:0], 1'b1);
            default: e.res = '0;
        endcase
        return e;
    endfunction

    function automatic logic [127:0] rand128();
        return {$urandom, $urandom, $urandom, $urandom};
    endfunction

    // mix of full random, small signed and corner operands
    function automatic logic [127:0] rand_operand();
        logic [127:0] v;
        case ($urandom_range(0, 9)) inside
            0: v = MIN128;
            1: v = ONES128;
            2: v = MIN128 - 128'd1;
            3: v = '0;
            4, 5: begin
                v = 128'($urandom_range(0, 1000));
                if ($urandom_range(0, 1)) v = -v;
            end
            default: v = rand128();
        endcase
        return v;
    endfunction

    function automatic alu_item_t rand_item();
        alu_item_t it;
        logic [127:0] c;
        it.op = op_t'($urandom_range(0, 15));
        it.a = rand_operand();
        it.b = rand_operand();
        case (it.op) inside
            OP_SHL, OP_SHR: if ($urandom_range(0, 3) != 0) begin
                c = 128'($urandom_range(0, 140));
                it.b = $urandom_range(0, 1) ? -c : c;
            end
            OP_ASUINT, OP_ASINT: begin
                it.b[127:64] = 64'(rand128());
                if ($urandom_range(0, 4) != 0) it.b[63:0] = 64'($urandom_range(0, 132));
            end
            // keep most exponents short so the run stays bounded
            OP_POW: if ($urandom_range(0, 19) != 0) it.b = 128'($urandom_range(0, 300));
            OP_DIV, OP_REM: if ($urandom_range(0, 5) == 0) it.b = '0;
            default: ;
        endcase
        return it;
    endfunction

    function automatic alu_item_t mk_item(op_t op, logic [127:0] a, logic [127:0] b);
        alu_item_t it;
        it.op = op;
        it.a = a;
        it.b = b;
        return it;
    endfunction

    // driver: holds the item until accepted, idles at random
    always @(posedge aclk) begin
        int idle_pct;
        idle_pct = (idle_phase == 0) ? 27 : (idle_phase == 1) ? 59 : 0;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (pending_items.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
                alu_item_t it;
                it = pending_items.pop_front();
                s_tdata <= {it.b[63:0], it.b[127:64], it.a[63:0], it.a[127:64]};
                s_tuser <= it.op;
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver stall
    always @(posedge aclk) begin
        int stall_pct;
        stall_pct = (idle_phase == 0) ? 59 : (idle_phase == 1) ? 27 : 0;
        if (!aresetn) m_tready <= 1'b0;
        else m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // monitor: predict on accept, check on result
    always @(posedge aclk) begin
        alu_item_t   it;
        alu_result_t got, want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                results_seen++;
                got.res = {m_tdata[63:0], m_tdata[127:64]};
                got.ok = m_tuser;
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result res=%h ok=%b", got.res, got.ok);
                end else begin
                    want = expected_results.pop_front();
                    if (got.res !== want.res || got.ok !== want.ok) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: res exp %h got %h, ok exp %b got %b",
                                     want.res, got.res, want.ok, got.ok);
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                it.op = op_t'(s_tuser);
                it.a = {s_tdata[63:0], s_tdata[127:64]};
                it.b = {s_tdata[191:128], s_tdata[255:192]};
                expected_results.push_back(alu_expect(it));
                items_sent++;
            end
        end
    end

    initial begin
        #50ms;
        $display("timeout");
        $display("int128_wrapping_alu_tb NOT OK");
        $finish;
    end

    initial begin
        // directed corners
        pending_items.push_back(mk_item(OP_ADD, ONES128, 128'd1));
        pending_items.push_back(mk_item(OP_SUB, MIN128, 128'd1));
        pending_items.push_back(mk_item(OP_MUL, ONES128, MIN128 - 128'd1));
        pending_items.push_back(mk_item(OP_NEG, MIN128, ONES128));
        pending_items.push_back(mk_item(OP_AND, ONES128, MIN128 - 128'd1));
        pending_items.push_back(mk_item(OP_OR, MIN128, 128'd1));
        pending_items.push_back(mk_item(OP_XOR, ONES128, MIN128));
        pending_items.push_back(mk_item(OP_NOT, '0, ONES128));
        pending_items.push_back(mk_item(OP_SHL, ONES128, -128'd5));
        pending_items.push_back(mk_item(OP_SHR, MIN128, -128'd3));
        pending_items.push_back(mk_item(OP_SHL, ONES128, 128'd128));
        pending_items.push_back(mk_item(OP_SHR, MIN128, 128'd200));
        pending_items.push_back(mk_item(OP_SHR, 128'd77, MIN128 - 128'd1));
        pending_items.push_back(mk_item(OP_DIV, MIN128, '0));
        pending_items.push_back(mk_item(OP_REM, ONES128, '0));
        pending_items.push_back(mk_item(OP_DIV, MIN128, ONES128));
        pending_items.push_back(mk_item(OP_REM, MIN128, ONES128));
        pending_items.push_back(mk_item(OP_DIV, -128'd7, 128'd2));
        pending_items.push_back(mk_item(OP_REM, -128'd7, 128'd2));
        pending_items.push_back(mk_item(OP_POW, 128'd3, ONES128));
        pending_items.push_back(mk_item(OP_POW, ONES128, '0));
        pending_items.push_back(mk_item(OP_ASUINT, ONES128, {ONES128[63:0], 64'd0}));
        pending_items.push_back(mk_item(OP_ASINT, MIN128 - 128'd1, 128'd128));
        pending_items.push_back(mk_item(OP_ASINT, 128'h80, 128'd8));
        pending_items.push_back(mk_item(OP_RSVD, ONES128, ONES128));
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        for (int i = 0; i < 650; i++) pending_items.push_back(rand_item());
        // phase changes follow accepted items
        while (items_sent < 240) @(posedge aclk);
        idle_phase = 1;
        while (items_sent < 460) @(posedge aclk);
        idle_phase = 2;
        while (pending_items.size() != 0 || s_tvalid || expected_results.size() != 0)
            @(posedge aclk);
        repeat (300) @(posedge aclk);
        $display("%0d items sent over all opcodes and corner cases, %0d results checked",
                 items_sent, results_seen);
        $display("three idling phases, %0d mismatches", mismatches);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("int128_wrapping_alu_tb OK");
        end else begin
            $display("int128_wrapping_alu_tb NOT OK");
        end
        $finish;
    end
endmodule
